FILE: hdl/isw_pkg.sv
package isw_pkg;

   localparam int unsigned IdxWidth  = 31;
   localparam int unsigned AddrWidth = 32;
   localparam int unsigned LenWidth  = 16;
   localparam int unsigned ProtWidth = 8;
   localparam int unsigned CsrIdxWidth = 3;

   // one stage per dividend bit, then address, sum and fold stages
   localparam int unsigned RemStages = IdxWidth;
   localparam int unsigned Latency   = RemStages + 3;

   localparam logic [31:0] HdrBytes = 32'd20;

   localparam logic [1:0] ModeFixed = 2'd0;
   localparam logic [1:0] ModeInc   = 2'd1;
   localparam logic [1:0] ModeDec   = 2'd2;

   localparam logic [CsrIdxWidth-1:0] RegSrcBase  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegSrcMask  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegSrcCount = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegSrcMode  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegDstBase  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] RegDstMask  = 3'd5;
   localparam logic [CsrIdxWidth-1:0] RegDstCount = 3'd6;
   localparam logic [CsrIdxWidth-1:0] RegDstMode  = 3'd7;

   typedef struct packed {
      logic [AddrWidth-1:0] base;
      logic [AddrWidth-1:0] mask;
      logic [AddrWidth-1:0] count;
      logic [1:0]           mode;
   } sweep_cfg_type;

   typedef struct packed {
      logic [LenWidth-1:0]  total_length;
      logic [ProtWidth-1:0] protocol_number;
   } side_type;

endpackage

FILE: hdl/isw_rem_pipe.sv
module isw_rem_pipe
   import isw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [IdxWidth-1:0]  in_index,
   input  side_type             in_side,
   input  logic [AddrWidth-1:0] src_count,
   input  logic [AddrWidth-1:0] dst_count,
   output logic                 out_valid,
   output logic [AddrWidth-1:0] out_src_off,
   output logic [AddrWidth-1:0] out_dst_off,
   output side_type             out_side
);

   // restoring remainder, one dividend bit per stage, both lanes side by side
   logic                 valid_ff [RemStages+1];
   logic [IdxWidth-1:0]  index_ff [RemStages+1];
   logic [AddrWidth-1:0] src_ff   [RemStages+1];
   logic [AddrWidth-1:0] dst_ff   [RemStages+1];
   side_type             side_ff  [RemStages+1];

   assign valid_ff[0] = in_valid;
   assign index_ff[0] = in_index;
   assign src_ff[0]   = '0;
   assign dst_ff[0]   = '0;
   assign side_ff[0]  = in_side;

   function automatic logic [AddrWidth-1:0] rem_step(input logic [AddrWidth-1:0] rem,
                                                      input logic bit_in,
                                                      input logic [AddrWidth-1:0] cnt);
      logic [AddrWidth:0] sh;
      logic [AddrWidth:0] diff;
      sh   = {rem, bit_in};
      diff = sh - {1'b0, cnt};
      if (sh >= {1'b0, cnt}) rem_step = diff[AddrWidth-1:0];
      else rem_step = sh[AddrWidth-1:0];
   endfunction

   for (genvar k = 0; k < RemStages; k++) begin : g_stage
      logic [AddrWidth-1:0] src_in;
      logic [AddrWidth-1:0] dst_in;
      assign src_in = rem_step(src_ff[k], index_ff[k][IdxWidth-1-k], src_count);
      assign dst_in = rem_step(dst_ff[k], index_ff[k][IdxWidth-1-k], dst_count);
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         index_ff[k+1] <= index_ff[k];
         src_ff[k+1]   <= src_in;
         dst_ff[k+1]   <= dst_in;
         side_ff[k+1]  <= side_ff[k];
      end
   end

   assign out_valid = valid_ff[RemStages];
   // zero count means no offset
   assign out_src_off = (src_count == '0) ? '0 : src_ff[RemStages];
   assign out_dst_off = (dst_count == '0) ? '0 : dst_ff[RemStages];
   assign out_side  = side_ff[RemStages];

endmodule

FILE: hdl/isw_addr_cksum.sv
module isw_addr_cksum
   import isw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [AddrWidth-1:0] src_off,
   input  logic [AddrWidth-1:0] dst_off,
   input  side_type             in_side,
   input  sweep_cfg_type        src_cfg,
   input  sweep_cfg_type        dst_cfg,
   output logic                 out_valid,
   output logic [AddrWidth-1:0] out_src,
   output logic [AddrWidth-1:0] out_dst,
   output logic [15:0]          out_cksum
);

   function automatic logic [AddrWidth-1:0] sweep(input sweep_cfg_type c,
                                                   input logic [AddrWidth-1:0] off);
      logic [AddrWidth-1:0] host;
      host = c.base & ~c.mask;
      case (c.mode)
         ModeInc: sweep = (c.base & c.mask) | ((host + off) & ~c.mask);
         ModeDec: sweep = (c.base & c.mask) | ((host - off) & ~c.mask);
         default: sweep = c.base;
      endcase
   endfunction

   logic                 a_valid_ff, b_valid_ff, c_valid_ff;
   logic [AddrWidth-1:0] a_src_ff, a_dst_ff, b_src_ff, b_dst_ff, c_src_ff, c_dst_ff;
   side_type             a_side_ff;
   logic [31:0]          b_sum_ff;
   logic [31:0]          b_sum_in;
   logic [16:0]          fold1;
   logic [16:0]          fold2;
   logic [15:0]          c_cksum_ff;

   assign b_sum_in = {16'd0, a_src_ff[31:16]} + {16'd0, a_src_ff[15:0]}
                   + {16'd0, a_dst_ff[31:16]} + {16'd0, a_dst_ff[15:0]}
                   + {24'd0, a_side_ff.protocol_number}
                   + ({16'd0, a_side_ff.total_length} - HdrBytes);

   // two folds bring any 32-bit sum into 16 bits
   assign fold1 = {1'b0, b_sum_ff[15:0]} + {1'b0, b_sum_ff[31:16]};
   assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      a_src_ff   <= sweep(src_cfg, src_off);
      a_dst_ff   <= sweep(dst_cfg, dst_off);
      a_side_ff  <= in_side;
      b_src_ff   <= a_src_ff;
      b_dst_ff   <= a_dst_ff;
      b_sum_ff   <= b_sum_in;
      c_src_ff   <= b_src_ff;
      c_dst_ff   <= b_dst_ff;
      c_cksum_ff <= ~fold2[15:0];
   end

   assign out_valid = c_valid_ff;
   assign out_src   = c_src_ff;
   assign out_dst   = c_dst_ff;
   assign out_cksum = c_cksum_ff;

endmodule

FILE: hdl/ipv4_address_sweep_pseudo_cksum_core.sv
// channel | ports                                          | handshake
// request | req_packet_index, req_total_length, req_protocol_number | start && !busy
// result  | rsp_src_addr, rsp_dst_addr, rsp_pseudo_cksum   | rsp_valid, one cycle
// config  | csr_index, csr_write_data                      | csr_write_en
// One word enters per cycle; busy stays low.
// A result passes 31 remainder stages (one index bit each, for both sweeps),
// then address, sum and fold/complement stages.
// Synchronous reset clears valid bits and restores register defaults.
// The receiver cannot stall, so the pipeline never holds.
module ipv4_address_sweep_pseudo_cksum_core
   import isw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [IdxWidth-1:0]    req_packet_index,
   input  logic [LenWidth-1:0]    req_total_length,
   input  logic [ProtWidth-1:0]   req_protocol_number,
   output logic                   rsp_valid,
   output logic [AddrWidth-1:0]   rsp_src_addr,
   output logic [AddrWidth-1:0]   rsp_dst_addr,
   output logic [15:0]            rsp_pseudo_cksum,
   input  logic                   csr_write_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [31:0]            csr_write_data
);

   sweep_cfg_type        src_cfg_ff, dst_cfg_ff;
   side_type             in_side;
   side_type             mid_side;
   logic                 mid_valid;
   logic [AddrWidth-1:0] src_off, dst_off;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_cfg_ff <= '{base: '0, mask: 32'hFFFF_FF00, count: 32'd1, mode: ModeFixed};
         dst_cfg_ff <= '{base: '0, mask: 32'hFFFF_FF00, count: 32'd1, mode: ModeFixed};
      end else if (csr_write_en) begin
         unique case (csr_index)
            RegSrcBase:  src_cfg_ff.base  <= csr_write_data;
            RegSrcMask:  src_cfg_ff.mask  <= csr_write_data;
            RegSrcCount: src_cfg_ff.count <= csr_write_data;
            RegSrcMode:  src_cfg_ff.mode  <= csr_write_data[1:0];
            RegDstBase:  dst_cfg_ff.base  <= csr_write_data;
            RegDstMask:  dst_cfg_ff.mask  <= csr_write_data;
            RegDstCount: dst_cfg_ff.count <= csr_write_data;
            RegDstMode:  dst_cfg_ff.mode  <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   assign in_side = '{total_length: req_total_length, protocol_number: req_protocol_number};

   isw_rem_pipe u_rem (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start && !busy),
      .in_index    (req_packet_index),
      .in_side     (in_side),
      .src_count   (src_cfg_ff.count),
      .dst_count   (dst_cfg_ff.count),
      .out_valid   (mid_valid),
      .out_src_off (src_off),
      .out_dst_off (dst_off),
      .out_side    (mid_side)
   );

   isw_addr_cksum u_cksum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .src_off   (src_off),
      .dst_off   (dst_off),
      .in_side   (mid_side),
      .src_cfg   (src_cfg_ff),
      .dst_cfg   (dst_cfg_ff),
      .out_valid (rsp_valid),
      .out_src   (rsp_src_addr),
      .out_dst   (rsp_dst_addr),
      .out_cksum (rsp_pseudo_cksum)
   );

endmodule

FILE: hdl/isw_checker.sv
module isw_checker
   import isw_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   logic [5:0] warm_ff;

   // count cycles since reset, saturate once the pipeline is full of known words
   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= '0;
      end else if (warm_ff != 6'(Latency)) begin
         warm_ff <= warm_ff + 6'd1;
      end
   end

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_quiet_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   a_word_gives_result: assert property (@(posedge clock) disable iff (reset)
      (warm_ff == 6'(Latency)) && $past(start && !busy, Latency) |-> rsp_valid)
      else $error("word lost");

   a_result_has_word: assert property (@(posedge clock) disable iff (reset)
      (warm_ff == 6'(Latency)) && rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without word");

endmodule

bind ipv4_address_sweep_pseudo_cksum_core isw_checker u_isw_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
